>>> rtl/core/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants for the wildcard pattern matcher cell chain.
// ----------------------------------------------------------------------------
package wpm_pkg;

  // Default number of pattern positions (cells in the chain).
  localparam int MAX_PATTERN_DEF = 64;

  // Wildcard symbols.
  localparam logic [7:0] SYM_STAR = 8'h2A;
  localparam logic [7:0] SYM_ANY  = 8'h3F;

  // Item function codes.
  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_TEXT   = 2'd2,
    FUNC_QUERY  = 2'd3
  } func_t;

  // Item traveling along the chain, with the values handed from a cell to its
  // right neighbor.
  typedef struct packed {
    logic       valid;  // Slot holds an item.
    func_t      func;   // What the item does.
    logic [7:0] sym;    // Pattern or text symbol.
    logic       left;   // Left row bit after the star ripple.
    logic       nleft;  // Left row bit after the text update.
    logic       res;    // Query result picked up so far.
    logic       done;   // Append already taken by a cell.
  } token_t;

endpackage

>>> rtl/core/wpm_cell.sv
// ----------------------------------------------------------------------------
// wpm_cell
// One pattern position: holds its pattern symbol and its row bit, updates
// them from the item passing by, and hands the item on through a register.
// ----------------------------------------------------------------------------
module wpm_cell
  import wpm_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  token_t tok_i,
  output token_t tok_o
);

  logic       active_r, active_nxt;
  logic       m_r, m_nxt;
  logic [7:0] sym_r, sym_nxt;
  logic       star_r, star_nxt;
  logic       any_r, any_nxt;
  token_t     tok_r, tok_nxt;
  logic       m_rip;
  logic       m_text;

  // Row bit after the star ripple, and the text update rule.
  always_comb begin
    m_rip = m_r | (active_r & star_r & tok_i.left);
    if ((tok_i.sym == sym_r) || any_r) begin
      m_text = tok_i.left;
    end else if (star_r) begin
      m_text = m_rip | tok_i.nleft;
    end else begin
      m_text = 1'b0;
    end
  end

  // Cell state and outgoing item.
  always_comb begin
    active_nxt = active_r;
    m_nxt      = m_r;
    sym_nxt    = sym_r;
    star_nxt   = star_r;
    any_nxt    = any_r;
    tok_nxt    = tok_i;
    if (tok_i.valid) begin
      unique case (tok_i.func)
        FUNC_CLEAR: begin
          active_nxt = 1'b0;
          m_nxt      = 1'b0;
        end
        FUNC_APPEND: begin
          if (!tok_i.done && !active_r) begin
            active_nxt   = 1'b1;
            m_nxt        = 1'b0;
            sym_nxt      = tok_i.sym;
            star_nxt     = (tok_i.sym == SYM_STAR);
            any_nxt      = (tok_i.sym == SYM_ANY);
            tok_nxt.done = 1'b1;
          end
        end
        FUNC_TEXT: begin
          if (active_r) begin
            m_nxt         = m_text;
            tok_nxt.left  = m_rip;
            tok_nxt.nleft = m_text;
          end else begin
            m_nxt         = 1'b0;
            tok_nxt.left  = 1'b0;
            tok_nxt.nleft = 1'b0;
          end
        end
        FUNC_QUERY: begin
          if (active_r) begin
            m_nxt        = 1'b0;
            tok_nxt.left = m_rip;
            tok_nxt.res  = m_rip;
          end
        end
        default: begin
          m_nxt = m_r;
        end
      endcase
    end
  end

  // Control state with reset, then the payload state without reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      tok_r.valid <= 1'b0;
    end else if (adv) begin
      active_r    <= active_nxt;
      tok_r.valid <= tok_nxt.valid;
    end
    if (adv) begin
      m_r         <= m_nxt;
      sym_r       <= sym_nxt;
      star_r      <= star_nxt;
      any_r       <= any_nxt;
      tok_r.func  <= tok_nxt.func;
      tok_r.sym   <= tok_nxt.sym;
      tok_r.left  <= tok_nxt.left;
      tok_r.nleft <= tok_nxt.nleft;
      tok_r.res   <= tok_nxt.res;
      tok_r.done  <= tok_nxt.done;
    end
  end

  assign tok_o = tok_r;

endmodule

>>> rtl/core/wildcard_pattern_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// Matches streamed text against a stored pattern with '?' and '*' wildcards,
// using a chain of one cell per pattern position.
// ----------------------------------------------------------------------------
// A query result passes through the MAX_PATTERN cell registers and then the
// output result register, as each item walks the chain one cell at a time.
// Throughput: one item per cycle; the chain stalls only when a query reaches
// the chain end while the previous result still waits in the output register.
// Reset: the pattern is empty, the overflow flag is clear and row bit zero
// is set; the pattern symbols and the cells' row bits are not cleared.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher
  import wpm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] symbol
  input  logic [1:0] in_tuser,   // [1:0] func
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] matched, [1] overflow, [7:2] zero
);

  token_t tok [0:MAX_PATTERN];
  token_t tail;
  logic   adv;
  logic   in_acc;
  logic   tail_query;
  logic   m0_r, m0_nxt;
  logic   ovf_r, ovf_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_matched_r;
  logic   out_ovf_r;

  assign tail       = tok[MAX_PATTERN];
  assign tail_query = tail.valid && (tail.func == FUNC_QUERY);

  // The chain moves unless a query would land on a result still waiting.
  assign adv       = !(tail_query && out_valid_r && !out_tready);
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;

  // Head: row bit zero and the item entering the first cell.
  always_comb begin
    tok[0].valid = in_acc;
    tok[0].func  = func_t'(in_tuser);
    tok[0].sym   = in_tdata;
    tok[0].left  = m0_r;
    tok[0].nleft = 1'b0;
    tok[0].res   = m0_r;
    tok[0].done  = 1'b0;
    m0_nxt       = m0_r;
    if (in_acc) begin
      unique case (func_t'(in_tuser))
        FUNC_CLEAR:  m0_nxt = 1'b1;
        FUNC_APPEND: m0_nxt = m0_r;
        FUNC_TEXT:   m0_nxt = 1'b0;
        FUNC_QUERY:  m0_nxt = 1'b1;
        default:     m0_nxt = m0_r;
      endcase
    end
  end

  // Cell chain, one cell per pattern position.
  for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cell
    wpm_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (tok[j-1]),
      .tok_o (tok[j])
    );
  end

  // Tail: sticky overflow flag, set by an append that found no free cell.
  always_comb begin
    ovf_nxt = ovf_r;
    if (adv && tail.valid) begin
      unique case (tail.func)
        FUNC_CLEAR:  ovf_nxt = 1'b0;
        FUNC_APPEND: ovf_nxt = ovf_r | !tail.done;
        FUNC_TEXT:   ovf_nxt = ovf_r;
        FUNC_QUERY:  ovf_nxt = ovf_r;
        default:     ovf_nxt = ovf_r;
      endcase
    end
  end

  assign out_valid_nxt = (adv && tail_query) || (out_valid_r && !out_tready);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m0_r        <= 1'b1;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      m0_r        <= m0_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output result register.
  always_ff @(posedge clk) begin
    if (adv && tail_query) begin
      out_matched_r <= tail.res;
      out_ovf_r     <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, out_ovf_r, out_matched_r};

`ifndef SYNTHESIS
  // Input is held off only by a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_valid_r && !out_tready))
    else $error("input stalled without a waiting result");

  // A clear leaving the chain drops the overflow flag.
  a_clear_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && tail.valid && (tail.func == FUNC_CLEAR)) |=> !ovf_r)
    else $error("overflow flag survived a clear");

  // A query restarts the row at bit zero.
  a_query_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == FUNC_QUERY)) |=> m0_r)
    else $error("row bit zero not set after a query");

  // A result appears only when a query leaves the chain.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(tail_query && adv))
    else $error("result without a query at the chain end");
`endif

endmodule
